[rtl/core/npcs_pkg.sv]
// ----------------------------------------------------------------------------
// npcs_pkg
// Shared types and constants of the nearest palette colour search core.
// ----------------------------------------------------------------------------
package npcs_pkg;

  localparam int unsigned PALETTE_DEPTH = 256;
  localparam int unsigned ADDR_W        = $clog2(PALETTE_DEPTH);
  localparam int unsigned CNT_W         = $clog2(PALETTE_DEPTH + 1);

  localparam int unsigned COLOR_W    = 8;
  localparam int unsigned FLAGS_W    = 8;
  localparam int unsigned SQ_W       = 2 * COLOR_W;
  localparam int unsigned DIST_W     = 22;
  localparam int unsigned IDX_W      = 9;
  localparam int unsigned ENTRY_W    = 3 * COLOR_W + FLAGS_W;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 9;

  localparam int unsigned W_RED   = 21;
  localparam int unsigned W_GREEN = 24;
  localparam int unsigned W_BLUE  = 10;

  localparam logic [IDX_W-1:0]   COUNT_RESET = IDX_W'(256);
  localparam logic [FLAGS_W-1:0] MASK_RESET  = FLAGS_W'(3);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_MASK   = 1'b1;

  typedef struct packed {
    logic                operation;
    logic [7:0]          entry_index;
    logic [COLOR_W-1:0]  red;
    logic [COLOR_W-1:0]  green;
    logic [COLOR_W-1:0]  blue;
    logic [FLAGS_W-1:0]  entry_flags;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0]  best_index;
    logic              found;
    logic [DIST_W-1:0] best_distance;
  } res_t;

  typedef struct packed {
    logic [FLAGS_W-1:0] flags;
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic write;
    logic load;
    logic issue;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_end;
    logic hit;
    logic pipe_busy;
  } dp_status_t;

endpackage

[rtl/core/npcs_ram.sv]
// ----------------------------------------------------------------------------
// npcs_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module npcs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/npcs_ctrl.sv]
// ----------------------------------------------------------------------------
// npcs_ctrl
// Sequencer: accepts requests, runs the palette scan and drains the pipeline.
// ----------------------------------------------------------------------------
module npcs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                operation_i,
  input  npcs_pkg::dp_status_t status_i,
  output npcs_pkg::dp_cmd_t   cmd_o,
  output logic                busy_o,
  output logic                res_valid_o
);

  npcs_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= npcs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      npcs_pkg::ST_IDLE: begin
        if (start_i && (operation_i == npcs_pkg::OP_QUERY)) begin
          state_d = npcs_pkg::ST_SCAN;
        end
      end
      npcs_pkg::ST_SCAN: begin
        if (status_i.scan_end || status_i.hit) begin
          state_d = npcs_pkg::ST_DRAIN;
        end
      end
      npcs_pkg::ST_DRAIN: begin
        if (!status_i.pipe_busy) begin
          state_d = npcs_pkg::ST_DONE;
        end
      end
      npcs_pkg::ST_DONE: begin
        state_d = npcs_pkg::ST_IDLE;
      end
      default: begin
        state_d = npcs_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    busy_o      = 1'b1;
    res_valid_o = 1'b0;
    case (state_q)
      npcs_pkg::ST_IDLE: begin
        busy_o      = 1'b0;
        cmd_o.write = start_i && (operation_i == npcs_pkg::OP_WRITE);
        cmd_o.load  = start_i && (operation_i == npcs_pkg::OP_QUERY);
      end
      npcs_pkg::ST_SCAN: begin
        cmd_o.issue = !status_i.scan_end && !status_i.hit;
      end
      npcs_pkg::ST_DRAIN: begin
        cmd_o.issue = 1'b0;
      end
      npcs_pkg::ST_DONE: begin
        res_valid_o = 1'b1;
      end
      default: begin
        busy_o = 1'b0;
      end
    endcase
  end

endmodule

[rtl/core/npcs_dp.sv]
// ----------------------------------------------------------------------------
// npcs_dp
// Datapath: palette memory, configuration, distance pipeline, best tracking.
// ----------------------------------------------------------------------------
module npcs_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [npcs_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [npcs_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  npcs_pkg::req_t                       req_i,
  input  npcs_pkg::dp_cmd_t                    cmd_i,
  output npcs_pkg::dp_status_t                 status_o,
  output npcs_pkg::res_t                       res_o
);

  localparam int unsigned ADDR_W = npcs_pkg::ADDR_W;
  localparam int unsigned CNT_W  = npcs_pkg::CNT_W;
  localparam int unsigned SQ_W   = npcs_pkg::SQ_W;
  localparam int unsigned DIST_W = npcs_pkg::DIST_W;
  localparam int unsigned CW     = npcs_pkg::COLOR_W;

  // configuration
  logic [npcs_pkg::IDX_W-1:0]   entry_count_q;
  logic [npcs_pkg::FLAGS_W-1:0] skip_mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= npcs_pkg::COUNT_RESET;
      skip_mask_q   <= npcs_pkg::MASK_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        npcs_pkg::CFG_ENTRY_COUNT: entry_count_q <= cfg_data_i[npcs_pkg::IDX_W-1:0];
        npcs_pkg::CFG_SKIP_MASK:   skip_mask_q   <= cfg_data_i[npcs_pkg::FLAGS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // query context
  logic [CNT_W-1:0]              count_q, count_sat;
  logic [npcs_pkg::FLAGS_W-1:0]  mask_q;
  logic [CW-1:0]                 qr_q, qg_q, qb_q;
  logic [CNT_W-1:0]              addr_q;

  always_comb begin
    if (32'(entry_count_q) > npcs_pkg::PALETTE_DEPTH) begin
      count_sat = CNT_W'(npcs_pkg::PALETTE_DEPTH);
    end else begin
      count_sat = CNT_W'(entry_count_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      count_q <= count_sat;
      mask_q  <= skip_mask_q;
      qr_q    <= req_i.red;
      qg_q    <= req_i.green;
      qb_q    <= req_i.blue;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
    end else if (cmd_i.load) begin
      addr_q <= '0;
    end else if (cmd_i.issue) begin
      addr_q <= addr_q + CNT_W'(1);
    end
  end

  // palette memory
  npcs_pkg::entry_t wentry, rentry;
  logic             ram_we;
  logic [31:0]      rdata;

  assign wentry.flags = req_i.entry_flags;
  assign wentry.blue  = req_i.blue;
  assign wentry.green = req_i.green;
  assign wentry.red   = req_i.red;
  assign ram_we = cmd_i.write && (32'(req_i.entry_index) < npcs_pkg::PALETTE_DEPTH);

  npcs_ram #(
    .WIDTH(npcs_pkg::ENTRY_W),
    .DEPTH(npcs_pkg::PALETTE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ADDR_W'(req_i.entry_index)),
    .wdata_i(wentry),
    .re_i   (cmd_i.issue),
    .raddr_i(addr_q[ADDR_W-1:0]),
    .rdata_o(rdata)
  );

  assign rentry = rdata;

  // pipeline
  logic             v1_q, v2_q, v3_q;
  logic [CNT_W-1:0] idx1_q, idx2_q, idx3_q;
  logic             elig2_q, elig3_q;
  logic [SQ_W-1:0]  sr_q, sg_q, sb_q;
  logic [DIST_W-1:0] dist_q;
  logic [CW-1:0]    dr, dg, db;

  assign dr = (rentry.red   > qr_q) ? (rentry.red   - qr_q) : (qr_q - rentry.red);
  assign dg = (rentry.green > qg_q) ? (rentry.green - qg_q) : (qg_q - rentry.green);
  assign db = (rentry.blue  > qb_q) ? (rentry.blue  - qb_q) : (qb_q - rentry.blue);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    idx1_q  <= addr_q;
    idx2_q  <= idx1_q;
    idx3_q  <= idx2_q;
    elig2_q <= (rentry.flags & mask_q) == '0;
    elig3_q <= elig2_q;
    sr_q    <= SQ_W'(dr) * SQ_W'(dr);
    sg_q    <= SQ_W'(dg) * SQ_W'(dg);
    sb_q    <= SQ_W'(db) * SQ_W'(db);
    dist_q  <= DIST_W'(sr_q) * DIST_W'(npcs_pkg::W_RED)
             + DIST_W'(sg_q) * DIST_W'(npcs_pkg::W_GREEN)
             + DIST_W'(sb_q) * DIST_W'(npcs_pkg::W_BLUE);
  end

  // best candidate
  logic              found_q, hit_q;
  logic [CNT_W-1:0]  best_idx_q;
  logic [DIST_W-1:0] best_d_q;
  logic              take;

  assign take = v3_q && elig3_q && !hit_q && (!found_q || (dist_q < best_d_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      hit_q   <= 1'b0;
    end else if (cmd_i.load) begin
      found_q <= 1'b0;
      hit_q   <= 1'b0;
    end else if (take) begin
      found_q <= 1'b1;
      hit_q   <= dist_q == '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      best_idx_q <= count_sat;
      best_d_q   <= '0;
    end else if (take) begin
      best_idx_q <= idx3_q;
      best_d_q   <= dist_q;
    end
  end

  assign status_o.scan_end  = addr_q >= count_q;
  assign status_o.hit       = hit_q;
  assign status_o.pipe_busy = v1_q || v2_q || v3_q;

  assign res_o.best_index    = npcs_pkg::IDX_W'(best_idx_q);
  assign res_o.found         = found_q;
  assign res_o.best_distance = best_d_q;

endmodule

[rtl/core/nearest_palette_color_search_core.sv]
// ----------------------------------------------------------------------------
// nearest_palette_color_search_core
// Weighted RGB nearest colour search over a writable palette.
// ----------------------------------------------------------------------------
// palette write: busy stays low, no result
// query: result strobe once N entries are read and the pipeline has drained, N =
//   entries read (saturated entry_count, fewer after an exact match);
//   one entry per cycle from the single read port, then a 3-stage pipeline
// one query at a time, busy high through the result cycle, next request taken
//   once busy falls after the result; receiver cannot stall
// reset: controller idle, entry_count 256, skip_flag_mask 3, palette undefined
module nearest_palette_color_search_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  npcs_pkg::req_t                 req_i,
  output logic                           res_valid_o,
  output npcs_pkg::res_t                 res_o,
  input  logic                           cfg_we_i,
  input  logic [npcs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [npcs_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  npcs_pkg::dp_cmd_t    cmd;
  npcs_pkg::dp_status_t status;

  npcs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .operation_i(req_i.operation),
    .status_i   (status),
    .cmd_o      (cmd),
    .busy_o     (busy_o),
    .res_valid_o(res_valid_o)
  );

  npcs_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .req_i     (req_i),
    .cmd_i     (cmd),
    .status_o  (status),
    .res_o     (res_o)
  );

  a_strobe_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("result strobe longer than one cycle");

  a_strobe_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> busy_o)
    else $error("result strobe outside a query");

  a_none_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.found) |-> (res_o.best_distance == '0))
    else $error("distance reported with nothing found");

  a_write_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (req_i.operation == npcs_pkg::OP_WRITE)) |=> !busy_o)
    else $error("palette write left the core busy");

endmodule

[bench/npcs_checker.sv]
// ----------------------------------------------------------------------------
// npcs_checker
// Watches the request, result and register ports of the nearest palette
// colour search core. It keeps its own palette and register copies, works
// out the nearest eligible entry for every accepted query, and compares each
// result strobe field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module npcs_checker
  import npcs_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  busy_i,
  input  req_t                  req_i,
  input  logic                  res_valid_i,
  input  res_t                  res_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned           fail_count_o,
  output int unsigned           pending_o,
  output int unsigned           writes_o,
  output int unsigned           queries_o,
  output int unsigned           exact_o,
  output int unsigned           none_o
);
  timeunit 1ns;
  timeprecision 1ps;

  entry_t             palette_copy [PALETTE_DEPTH];
  logic [CNT_W-1:0]   ent_count;
  logic [FLAGS_W-1:0] skip_mask;
  res_t               nearest_q [$];
  res_t               oldest;
  res_t               fresh;
  int unsigned        errors;
  int unsigned        n_writes;
  int unsigned        n_queries;
  int unsigned        n_exact;
  int unsigned        n_none;

  function automatic int unsigned abs_diff(input logic [COLOR_W-1:0] a,
                                           input logic [COLOR_W-1:0] b);
    return (a > b) ? int'(a - b) : int'(b - a);
  endfunction

  function automatic res_t predict_nearest(input logic [COLOR_W-1:0] r,
                                           input logic [COLOR_W-1:0] g,
                                           input logic [COLOR_W-1:0] b);
    res_t        res;
    int unsigned n;
    int unsigned i;
    int unsigned dr;
    int unsigned dg;
    int unsigned db;
    int unsigned d;
    logic        hit;
    n = (ent_count > PALETTE_DEPTH) ? PALETTE_DEPTH : ent_count;
    res = '0;
    res.best_index = IDX_W'(n);
    hit = 1'b0;
    // an exact match stops the scan
    for (i = 0; i < n && !(hit && res.best_distance == 0); i++) begin
      if ((palette_copy[i].flags & skip_mask) == '0) begin
        dr = abs_diff(palette_copy[i].red, r);
        dg = abs_diff(palette_copy[i].green, g);
        db = abs_diff(palette_copy[i].blue, b);
        d = W_RED * dr * dr + W_GREEN * dg * dg + W_BLUE * db * db;
        if (!hit || d < res.best_distance) begin
          hit = 1'b1;
          res.best_distance = DIST_W'(d);
          res.best_index = IDX_W'(i);
        end
      end
    end
    res.found = hit;
    return res;
  endfunction

  task automatic report_mismatch(input string line);
    $display("%0t ns: %s", $realtime, line);
    errors++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d expected %0d", what, got, want));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_count = COUNT_RESET;
      skip_mask = MASK_RESET;
      nearest_q.delete();
      errors = 0;
      n_writes = 0;
      n_queries = 0;
      n_exact = 0;
      n_none = 0;
    end else begin
      if (cfg_we_i === 1'b1) begin
        case (cfg_idx_i)
          CFG_ENTRY_COUNT: ent_count = cfg_data_i;
          CFG_SKIP_MASK:   skip_mask = cfg_data_i[FLAGS_W-1:0];
          default: ;
        endcase
      end
      if (res_valid_i === 1'b1) begin
        if (nearest_q.size() == 0) begin
          report_mismatch($sformatf("result index %0d with no query outstanding",
                                    res_i.best_index));
        end else begin
          oldest = nearest_q.pop_front();
          check_field("best_index", res_i.best_index, oldest.best_index);
          check_field("found", res_i.found, oldest.found);
          check_field("best_distance", res_i.best_distance, oldest.best_distance);
        end
      end
      if (start_i === 1'b1 && busy_i === 1'b0) begin
        if (req_i.operation == OP_WRITE) begin
          palette_copy[req_i.entry_index] = {req_i.entry_flags, req_i.blue,
                                             req_i.green, req_i.red};
          n_writes++;
        end else begin
          fresh = predict_nearest(req_i.red, req_i.green, req_i.blue);
          nearest_q.push_back(fresh);
          n_queries++;
          if (!fresh.found) begin
            n_none++;
          end else if (fresh.best_distance == 0) begin
            n_exact++;
          end
        end
      end
    end
    fail_count_o <= errors;
    pending_o <= nearest_q.size();
    writes_o <= n_writes;
    queries_o <= n_queries;
    exact_o <= n_exact;
    none_o <= n_none;
  end

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the nearest palette colour search core. A short
// directed sequence covers empty searches, exact hits, ties, skipped entries
// and the largest distance; the palette is then filled and random writes and
// queries run under a series of register settings with random idling.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import npcs_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 620;

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  start_i    = 1'b0;
  logic                  busy_o;
  req_t                  req_i      = '0;
  logic                  res_valid_o;
  res_t                  res_o;
  logic                  cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i  = CFG_ENTRY_COUNT;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned n_writes;
  int unsigned n_queries;
  int unsigned n_exact;
  int unsigned n_none;

  entry_t      shadow [PALETTE_DEPTH];
  int unsigned cur_count;
  int unsigned phase_no = 0;
  int unsigned rand_done = 0;
  bit          no_gaps = 1'b0;

  always #6 clk_i = ~clk_i;

  nearest_palette_color_search_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .req_i      (req_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  npcs_checker chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_i      (busy_o),
    .req_i       (req_i),
    .res_valid_i (res_valid_o),
    .res_i       (res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .writes_o    (n_writes),
    .queries_o   (n_queries),
    .exact_o     (n_exact),
    .none_o      (n_none)
  );

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [COLOR_W-1:0] pick_color();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return COLOR_W'($urandom);
  endfunction

  task automatic issue(input req_t r);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    if (r.operation == OP_WRITE) begin
      shadow[r.entry_index] = {r.entry_flags, r.blue, r.green, r.red};
    end
  endtask

  task automatic put_entry(input logic [7:0] idx, input logic [COLOR_W-1:0] r,
                           input logic [COLOR_W-1:0] g, input logic [COLOR_W-1:0] b,
                           input logic [FLAGS_W-1:0] fl);
    req_t q;
    q = '{operation: OP_WRITE, entry_index: idx, red: r, green: g, blue: b,
          entry_flags: fl};
    issue(q);
  endtask

  task automatic ask_nearest(input logic [COLOR_W-1:0] r, input logic [COLOR_W-1:0] g,
                             input logic [COLOR_W-1:0] b);
    req_t q;
    q = '{operation: OP_QUERY, entry_index: 8'($urandom), red: r, green: g, blue: b,
          entry_flags: FLAGS_W'($urandom)};
    issue(q);
  endtask

  task automatic settle();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 || busy_o !== 1'b0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apply_config(input logic [CFG_DATA_W-1:0] count,
                              input logic [CFG_DATA_W-1:0] mask_data);
    settle();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_ENTRY_COUNT;
    cfg_data_i <= count;
    @(posedge clk_i);
    cfg_idx_i <= CFG_SKIP_MASK;
    cfg_data_i <= mask_data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_count = (count > PALETTE_DEPTH) ? PALETTE_DEPTH : count;
    phase_no++;
  endtask

  task automatic random_write();
    entry_t src;
    src = shadow[$urandom_range(0, PALETTE_DEPTH - 1)];
    if ($urandom_range(0, 3) == 0) begin
      // duplicate colour to provoke ties
      put_entry(8'($urandom), src.red, src.green, src.blue,
                ($urandom_range(0, 1) == 0) ? '0 : FLAGS_W'($urandom));
    end else begin
      put_entry(8'($urandom), pick_color(), pick_color(), pick_color(),
                ($urandom_range(0, 1) == 0) ? '0 : FLAGS_W'($urandom));
    end
  endtask

  task automatic random_query();
    entry_t src;
    if (cur_count != 0 && $urandom_range(0, 9) < 4) begin
      src = shadow[$urandom_range(0, cur_count - 1)];
      ask_nearest(src.red, src.green, src.blue);
    end else begin
      ask_nearest(pick_color(), pick_color(), pick_color());
    end
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] count;
    logic [CFG_DATA_W-1:0] mask_data;
    int unsigned           len;
    int unsigned           waited;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty search range
    apply_config(9'd0, 9'd0);
    ask_nearest(8'h00, 8'h00, 8'h00);
    ask_nearest(8'hFF, 8'hFF, 8'hFF);

    put_entry(8'd0, 8'hFF, 8'hFF, 8'hFF, 8'h80);
    put_entry(8'd1, 8'h00, 8'h00, 8'h00, 8'h01);
    put_entry(8'd2, 8'h00, 8'h00, 8'h00, 8'h00);
    put_entry(8'd3, 8'hFF, 8'h00, 8'hFF, 8'h02);
    put_entry(8'd4, 8'h0A, 8'h14, 8'h1E, 8'hFF);
    put_entry(8'd5, 8'h00, 8'h00, 8'h00, 8'h00);

    apply_config(9'd6, 9'd0);
    ask_nearest(8'h00, 8'h00, 8'h00);
    ask_nearest(8'hFF, 8'hFF, 8'hFF);
    ask_nearest(8'h80, 8'h7F, 8'h80);

    // low flag bits skipped, tie between slots 2 and 5
    apply_config(9'd6, 9'd3);
    ask_nearest(8'h00, 8'h00, 8'h00);
    ask_nearest(8'hFF, 8'hFF, 8'hFF);

    // full mask with the unused top data bit set, largest distance
    apply_config(9'd6, 9'h1FF);
    ask_nearest(8'hFF, 8'hFF, 8'hFF);

    apply_config(9'd2, 9'h07F);
    ask_nearest(8'h00, 8'h00, 8'h00);

    // nothing eligible
    apply_config(9'd1, 9'h080);
    ask_nearest(8'h12, 8'h34, 8'h56);

    settle();
    for (int unsigned i = 0; i < PALETTE_DEPTH; i++) begin
      put_entry(8'(i), pick_color(), pick_color(), pick_color(),
                ($urandom_range(0, 1) == 0) ? '0 : FLAGS_W'($urandom));
    end

    while (rand_done < RANDOM_ITEMS) begin
      case (phase_no)
        7:  begin count = 9'd256; mask_data = 9'd0;   end
        8:  begin count = 9'd511; mask_data = 9'h1FF; end
        9:  begin count = 9'd0;   mask_data = 9'h0FF; end
        10: begin count = 9'd1;   mask_data = 9'd0;   end
        11: begin count = 9'd255; mask_data = 9'd3;   end
        default: begin
          case ($urandom_range(0, 9))
            0:       count = 9'd0;
            1:       count = 9'd1;
            2, 3, 4, 5: count = 9'($urandom_range(2, 16));
            6, 7:    count = 9'($urandom_range(17, 255));
            8:       count = 9'd256;
            default: count = 9'($urandom_range(257, 511));
          endcase
          case ($urandom_range(0, 3))
            0:       mask_data = 9'd0;
            1:       mask_data = {1'($urandom), 8'hFF};
            2:       mask_data = 9'd3;
            default: mask_data = 9'($urandom);
          endcase
        end
      endcase
      apply_config(count, mask_data);
      no_gaps = ($urandom_range(0, 3) == 0);
      len = $urandom_range(20, 60);
      repeat (len) begin
        if ($urandom_range(0, 9) < 4) begin
          random_write();
        end else begin
          random_query();
        end
        rand_done++;
        if ($urandom_range(0, 99) < 3) begin
          settle();
        end
      end
    end

    start_i <= 1'b0;
    @(posedge clk_i);
    waited = 0;
    while (pending != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending != 0) begin
      $display("SCOREBOARD MISMATCH");
    end else begin
      repeat (300) @(posedge clk_i);
      $display("run covered %0d palette writes and %0d searches over %0d register settings",
               n_writes, n_queries, phase_no);
      $display("searches: %0d exact hits, %0d nearest entries, %0d with nothing eligible",
               n_exact, n_queries - n_exact - n_none, n_none);
      if (fail_count == 0 && pending == 0) begin
        $display("SCOREBOARD CLEAN");
      end else begin
        $display("SCOREBOARD MISMATCH");
      end
    end
    $finish;
  end

  initial begin
    #25_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
